// ===== hdl/apl_pkg.sv =====
// apl_pkg: shared types and codes for the positional array list.
// No dependencies; imported by apl_ctrl, apl_datapath and positional_array_list.
`default_nettype none

package apl_pkg;

    localparam int CMD_W   = 2;
    localparam int POS_W   = 5;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 6;

    // command codes; the fourth code is unused and answered with an error
    typedef enum logic [CMD_W-1:0] {
        OP_GET    = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2
    } apl_op_t;

    // controller -> datapath
    typedef struct packed {
        logic exec;     // execute the command on the input ports this cycle
    } apl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic full;     // list holds CAPACITY entries
        logic empty;    // list holds no entry
    } apl_stat_t;

endpackage : apl_pkg

`default_nettype wire

// ===== hdl/apl_ctrl.sv =====
// apl_ctrl: handshake controller for the positional array list.
// Depends on apl_pkg (command and status structs).
`default_nettype none

module apl_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  wire logic               m_ready,
    input  wire apl_pkg::apl_stat_t stat,
    output apl_pkg::apl_cmd_t       cmd
);
    import apl_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_OUT  = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   take;
    logic   unused_stat;

    assign unused_stat = stat.full ^ stat.empty;

    // a new beat may enter while the held result is leaving
    always_comb begin
        s_ready = 1'b0;
        m_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_OUT: begin
                m_valid = 1'b1;
                s_ready = m_ready;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    assign take     = s_valid & s_ready;
    assign cmd.exec = take;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (take) state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready && !take) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule : apl_ctrl

`default_nettype wire

// ===== hdl/apl_datapath.sv =====
// apl_datapath: shifting entry row, length register and result registers.
// Depends on apl_pkg (codes, widths, command and status structs).
`default_nettype none

module apl_datapath #(
    parameter int CAPACITY = 32
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire apl_pkg::apl_cmd_t           cmd,
    output apl_pkg::apl_stat_t               stat,
    input  wire logic [apl_pkg::CMD_W-1:0]   s_cmd,
    input  wire logic [apl_pkg::POS_W-1:0]   s_position,
    input  wire logic signed [apl_pkg::DATA_W-1:0] s_new_value,
    output logic                             m_status,
    output logic signed [apl_pkg::DATA_W-1:0] m_read_value,
    output logic [apl_pkg::COUNT_W-1:0]      m_count_after
);
    import apl_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);          // length width
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int PW = (CW > POS_W) ? CW : POS_W;      // compare width
    localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);

    logic [DATA_W-1:0] entries_reg [CAPACITY];
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;

    logic [PW-1:0]     pos_p;
    logic [PW-1:0]     cnt_p;
    logic              pos_in;     // position below length
    logic              ins_ok;
    logic              get_ok;
    logic              del_ok;
    logic              do_ins;
    logic              do_del;
    logic              ok;
    logic [DATA_W-1:0] rd_word;
    logic [DATA_W-1:0] val_next;
    logic [CW+COUNT_W-1:0] cnt_ext;

    logic              status_reg;
    logic [DATA_W-1:0] read_value_reg;
    logic [COUNT_W-1:0] count_after_reg;

    assign pos_p  = PW'(s_position);
    assign cnt_p  = PW'(count_reg);
    assign pos_in = pos_p < cnt_p;

    assign stat.full  = (cnt_p == CAP_P);
    assign stat.empty = (count_reg == '0);

    always_comb begin
        get_ok = 1'b0;
        ins_ok = 1'b0;
        del_ok = 1'b0;
        case (s_cmd)
            OP_GET:    get_ok = pos_in;
            OP_INSERT: ins_ok = !stat.full && (pos_p <= cnt_p);
            OP_DELETE: del_ok = pos_in;
            default: begin
                get_ok = 1'b0;
            end
        endcase
    end

    assign ok     = get_ok | ins_ok | del_ok;
    assign do_ins = cmd.exec & ins_ok;
    assign do_del = cmd.exec & del_ok;

    // single read port at the commanded position; only used when in range
    assign rd_word  = entries_reg[pos_p[AW-1:0]];
    assign val_next = (get_ok || del_ok) ? rd_word : '0;

    always_comb begin
        count_next = count_reg;
        if (do_ins) count_next = count_reg + 1'b1;
        else if (do_del) count_next = count_reg - 1'b1;
    end

    assign cnt_ext = {{COUNT_W{1'b0}}, count_next};

    // each cell picks its own next word from its neighbors
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        localparam logic [PW-1:0] IDX = PW'(i);
        always_ff @(posedge aclk) begin
            if (do_ins) begin
                if (IDX == pos_p) begin
                    entries_reg[i] <= s_new_value;
                end else if (IDX > pos_p) begin
                    entries_reg[i] <= entries_reg[(i > 0) ? i - 1 : 0];
                end
            end else if (do_del) begin
                if (IDX >= pos_p && i < CAPACITY - 1) begin
                    entries_reg[i] <= entries_reg[(i < CAPACITY - 1) ? i + 1 : i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            status_reg      <= ~ok;
            read_value_reg  <= val_next;
            count_after_reg <= cnt_ext[COUNT_W-1:0];
        end
    end

    assign m_status      = status_reg;
    assign m_read_value  = signed'(read_value_reg);
    assign m_count_after = count_after_reg;

endmodule : apl_datapath

`default_nettype wire

// ===== hdl/positional_array_list.sv =====
// positional_array_list: top level of the fixed-capacity positional list.
// Depends on apl_pkg, apl_ctrl and apl_datapath.
//
//  channel | ports                                   | dir | handshake
//  --------+-----------------------------------------+-----+-----------------
//  command | s_cmd, s_position, s_new_value          | in  | s_valid/s_ready
//  result  | m_status, m_read_value, m_count_after   | out | m_valid/m_ready
//
// A command beat is executed in the cycle it is accepted: get, insert and
// delete all finish in that same cycle, every entry cell shifting in parallel.
// The result beat is presented from the next cycle on; with m_ready held
// high a new command is accepted every cycle, so the rate is one per cycle.
// When the result stalls, s_ready drops until it is taken; the list is held.
// Reset (aresetn low, synchronous) empties the list and drops m_valid; entry
// contents are not cleared, since only positions below the length are read.
`default_nettype none

module positional_array_list #(
    parameter int CAPACITY = 32
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [apl_pkg::CMD_W-1:0]           s_cmd,
    input  wire logic [apl_pkg::POS_W-1:0]           s_position,
    input  wire logic signed [apl_pkg::DATA_W-1:0]   s_new_value,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic                                     m_status,
    output logic signed [apl_pkg::DATA_W-1:0]        m_read_value,
    output logic [apl_pkg::COUNT_W-1:0]              m_count_after
);
    import apl_pkg::*;

    apl_cmd_t  cmd;
    apl_stat_t stat;

    // controller: owns both handshakes and the result-pending state
    apl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // datapath: entry row, length and registered result fields
    apl_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .s_cmd         (s_cmd),
        .s_position    (s_position),
        .s_new_value   (s_new_value),
        .m_status      (m_status),
        .m_read_value  (m_read_value),
        .m_count_after (m_count_after)
    );

endmodule : positional_array_list

`default_nettype wire

// ===== test/positional_array_list_checker.sv =====
// Checker for the positional array list: mirrors the list, predicts each result beat.
// Depends on apl_pkg; instantiated beside the block by positional_array_list_tb.
`timescale 1ns / 100ps

module positional_array_list_checker #(
    parameter int CAPACITY = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic [apl_pkg::CMD_W-1:0]         s_cmd,
    input  logic [apl_pkg::POS_W-1:0]         s_position,
    input  logic signed [apl_pkg::DATA_W-1:0] s_new_value,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic                              m_status,
    input  logic signed [apl_pkg::DATA_W-1:0] m_read_value,
    input  logic [apl_pkg::COUNT_W-1:0]       m_count_after,
    output int                                fail_count,
    output int                                results_due,
    output logic [apl_pkg::COUNT_W-1:0]       list_len
);
    import apl_pkg::*;

    typedef struct packed {
        logic                     status;
        logic signed [DATA_W-1:0] value;
        logic [COUNT_W-1:0]       length;
    } list_reply_t;

    logic signed [DATA_W-1:0] list_words [CAPACITY];
    list_reply_t              replies_q [$];

    // applies one command to the local list copy and returns the reply it earns
    function automatic list_reply_t apply_list_command(input logic [CMD_W-1:0] op,
                                                       input logic [POS_W-1:0] pos,
                                                       input logic signed [DATA_W-1:0] word);
        list_reply_t r;
        int          k;
        r.status = 1'b1;
        r.value  = '0;
        case (op)
            OP_GET: begin
                if (pos < list_len && pos < CAPACITY) begin
                    r.status = 1'b0;
                    r.value  = list_words[pos];
                end
            end
            OP_INSERT: begin
                if (list_len < CAPACITY && pos <= list_len) begin
                    for (k = list_len; k > pos; k--)
                        list_words[k] = list_words[k-1];
                    list_words[pos] = word;
                    list_len        = list_len + 1'b1;
                    r.status        = 1'b0;
                end
            end
            OP_DELETE: begin
                if (pos < list_len && pos < CAPACITY) begin
                    r.value = list_words[pos];
                    for (k = pos; k + 1 < list_len && k + 1 < CAPACITY; k++)
                        list_words[k] = list_words[k+1];
                    list_len = list_len - 1'b1;
                    r.status = 1'b0;
                end
            end
            default: ; // unused code: error, list untouched
        endcase
        r.length = list_len;
        return r;
    endfunction

    initial begin
        fail_count  = 0;
        results_due = 0;
        list_len    = '0;
        foreach (list_words[i]) list_words[i] = '0;
    end

    always @(posedge aclk) begin
        list_reply_t want;
        if (!aresetn) begin
            list_len = '0;
            replies_q.delete();
        end else begin
            // result side first: a beat leaving now belongs to an older command
            if (m_valid && m_ready) begin
                if (replies_q.size() == 0) begin
                    $display("%0t: unexpected result beat (status %0d value %0d length %0d)",
                             $time, m_status, m_read_value, m_count_after);
                    fail_count++;
                end else begin
                    want = replies_q.pop_front();
                    if (m_status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, m_status);
                        fail_count++;
                    end
                    if (m_read_value !== want.value) begin
                        $display("%0t: read_value expected %0d actual %0d",
                                 $time, want.value, m_read_value);
                        fail_count++;
                    end
                    if (m_count_after !== want.length) begin
                        $display("%0t: count_after expected %0d actual %0d",
                                 $time, want.length, m_count_after);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready)
                replies_q.push_back(apply_list_command(s_cmd, s_position, s_new_value));
        end
        results_due = replies_q.size();
    end

endmodule

// ===== test/positional_array_list_tb.sv =====
// Testbench top for positional_array_list: clock, reset, command stimulus and verdict.
// Depends on apl_pkg, the block under test and positional_array_list_checker.
`timescale 1ns / 100ps

module positional_array_list_tb;
    import apl_pkg::*;

    localparam int                 CAPACITY  = 32;
    // fourth command code has no enum member; the block must answer it with an error
    localparam logic [CMD_W-1:0]   OP_UNUSED = 2'd3;
    localparam int                 BEATS_PER_PHASE = 510;
    localparam int                 DRAIN_CYCLES    = 10;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic [CMD_W-1:0]         s_cmd;
    logic [POS_W-1:0]         s_position;
    logic signed [DATA_W-1:0] s_new_value;
    logic                     m_valid;
    logic                     m_ready;
    logic                     m_status;
    logic signed [DATA_W-1:0] m_read_value;
    logic [COUNT_W-1:0]       m_count_after;

    int                       fail_count;
    int                       results_due;
    logic [COUNT_W-1:0]       list_len;

    // percent of cycles each side sits idle; changed per phase
    int                       tx_idle_pct;
    int                       rx_idle_pct;

    positional_array_list #(.CAPACITY(CAPACITY)) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_position    (s_position),
        .s_new_value   (s_new_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_read_value  (m_read_value),
        .m_count_after (m_count_after)
    );

    positional_array_list_checker #(.CAPACITY(CAPACITY)) checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_position    (s_position),
        .s_new_value   (s_new_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_read_value  (m_read_value),
        .m_count_after (m_count_after),
        .fail_count    (fail_count),
        .results_due   (results_due),
        .list_len      (list_len)
    );

    // 2 ns clock
    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // receiver back-pressure, redrawn every falling edge
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // hard stop well past the slowest legal run
    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Drive one command beat, starting and ending on a falling edge.
    // Idle cycles (valid low) come first; once raised, valid holds until accepted.
    task automatic send_command(input logic [CMD_W-1:0] op, input logic [POS_W-1:0] pos,
                                input logic signed [DATA_W-1:0] word);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_cmd       <= op;
        s_position  <= pos;
        s_new_value <= word;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // sender holds off until every outstanding result beat has come back
    task automatic drain_results();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (results_due != 0) @(negedge aclk);
    endtask

    // data word, weighted toward the signed extremes, minus one and zero
    function automatic logic signed [DATA_W-1:0] pick_word();
        int roll;
        roll = $urandom_range(0, 9);
        case (roll)
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return -32'sd1;
            3:       return 32'sd0;
            default: return $urandom();
        endcase
    endfunction

    // One random phase. Mostly well-formed commands whose positions fall
    // inside the current list, with the mix drifting between growing and
    // shrinking so the list swings between empty and full. A slice is noise:
    // any position, any legal code, and now and then the unused code.
    task automatic run_random_phase(input int beats);
        int                 i;
        int                 roll;
        int                 mood_left;
        bit                 growing;
        logic [CMD_W-1:0]   op;
        logic [POS_W-1:0]   pos;
        growing   = 1'b1;
        mood_left = $urandom_range(40, 120);
        for (i = 0; i < beats; i++) begin
            if (mood_left == 0) begin
                growing   = !growing;
                mood_left = $urandom_range(40, 120);
            end
            mood_left--;
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                op  = OP_UNUSED;
                pos = POS_W'($urandom());
            end else if (roll < 12) begin
                op  = CMD_W'($urandom_range(OP_GET, OP_DELETE));
                pos = POS_W'($urandom());
            end else begin
                roll = $urandom_range(0, 99);
                if (growing)
                    op = (roll < 70) ? OP_INSERT : (roll < 85) ? OP_GET : OP_DELETE;
                else
                    op = (roll < 65) ? OP_DELETE : (roll < 85) ? OP_GET : OP_INSERT;
                if (op == OP_INSERT)
                    pos = (list_len > 31) ? 5'd31 : POS_W'($urandom_range(0, list_len));
                else
                    pos = (list_len == 0) ? 5'd0 : POS_W'($urandom_range(0, list_len - 1));
            end
            send_command(op, pos, pick_word());
            // occasional full stop of the sender mid-phase
            if ($urandom_range(0, 99) == 0)
                drain_results();
        end
    endtask

    initial begin
        // every input known from time zero
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_cmd       = OP_GET;
        s_position  = '0;
        s_new_value = '0;
        m_ready     = 1'b0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: empty-list errors, inserts at front/middle/end, extremes
        send_command(OP_GET,    5'd0,  32'sd0);          // get on empty
        send_command(OP_DELETE, 5'd0,  32'sd0);          // delete on empty
        send_command(OP_INSERT, 5'd1,  32'sd9);          // insert past the end
        send_command(OP_INSERT, 5'd0,  32'sh8000_0000);  // first entry, most negative
        send_command(OP_INSERT, 5'd1,  32'sh7fff_ffff);  // append, most positive
        send_command(OP_INSERT, 5'd0,  -32'sd1);         // push at front
        send_command(OP_INSERT, 5'd1,  32'sd0);          // middle
        send_command(OP_GET,    5'd0,  32'sd0);
        send_command(OP_GET,    5'd1,  32'sd0);
        send_command(OP_GET,    5'd2,  32'sd0);
        send_command(OP_GET,    5'd3,  32'sd0);
        send_command(OP_GET,    5'd4,  32'sd0);          // get at the length
        send_command(OP_GET,    5'd31, 32'sd0);          // far past the end
        send_command(OP_UNUSED, 5'd31, -32'sd1);         // unused code
        send_command(OP_DELETE, 5'd1,  -32'sd1);         // delete middle, new_value ignored
        send_command(OP_DELETE, 5'd2,  32'sd0);          // delete last
        send_command(OP_DELETE, 5'd2,  32'sd0);          // delete at the length
        send_command(OP_INSERT, 5'd31, 32'sd5);          // insert far past the end
        send_command(OP_DELETE, 5'd0,  32'sd0);
        send_command(OP_DELETE, 5'd0,  32'sd0);          // list empty again
        send_command(OP_GET,    5'd0,  32'sd0);
        drain_results();

        // slow sender, very slow receiver
        tx_idle_pct = 32;
        rx_idle_pct = 86;
        run_random_phase(BEATS_PER_PHASE);
        drain_results();

        // the other way round
        tx_idle_pct = 86;
        rx_idle_pct = 32;
        run_random_phase(BEATS_PER_PHASE);
        drain_results();

        // full rate both sides
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random_phase(BEATS_PER_PHASE);

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0 && results_due == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/apl_pkg.sv
hdl/apl_ctrl.sv
hdl/apl_datapath.sv
hdl/positional_array_list.sv
test/positional_array_list_checker.sv
test/positional_array_list_tb.sv
